>>> design/rate_threshold_ban_table_top_macros.svh
// Assertion macros used by the rate threshold ban table back end.
`ifndef RATE_THRESHOLD_BAN_TABLE_TOP_MACROS_SVH
`define RATE_THRESHOLD_BAN_TABLE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, clocked on clk, off during reset
`define RTBT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, clocked on clk, off during reset
`define RTBT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RTBT_ASSERT_IMP(label, ante, cons)
`define RTBT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> design/rtbt_pkg.sv
// Types, constants and field layout for the rate threshold ban table.
package rtbt_pkg;

	// Table size and derived widths
	localparam int BAN_SLOTS  = 16;
	localparam int SLOT_W     = (BAN_SLOTS > 1) ? $clog2(BAN_SLOTS) : 1;
	localparam int MAX_EVENTS = 16;
	localparam int EVT_CNT_W  = $clog2(MAX_EVENTS + 1);

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Field widths
	localparam int ADDR_W    = 32;
	localparam int TIME_W    = 32;
	localparam int PROTO_W   = 8;
	localparam int RATE_W    = 32;
	localparam int BITS_W    = 40;
	localparam int FLOWS_W   = 32;
	localparam int FLAGS_W   = 8;
	localparam int MBPS_W    = 21;
	localparam int HOLD_W    = 24;
	localparam int THR_W     = BITS_W + 1;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int KIND_W    = 2;

	// Input tdata layout, lowest field first
	localparam int OFF_NOW    = 0;
	localparam int OFF_ADDR   = OFF_NOW + TIME_W;
	localparam int OFF_PROTO  = OFF_ADDR + ADDR_W;
	localparam int OFF_PPS    = OFF_PROTO + PROTO_W;
	localparam int OFF_BITS   = OFF_PPS + RATE_W;
	localparam int OFF_FLOWS  = OFF_BITS + BITS_W;
	localparam int OFF_FLAGS  = OFF_FLOWS + FLOWS_W;
	localparam int OFF_EXEMPT = OFF_FLAGS + FLAGS_W;
	localparam int S_TDATA_W  = ((OFF_EXEMPT + 1 + 7) / 8) * 8;
	localparam int M_TDATA_W  = ((ADDR_W + PROTO_W + 7) / 8) * 8;

	// Constants
	localparam logic [THR_W-1:0]   BITS_PER_MEGABIT = THR_W'(1000000);
	localparam logic [FLAGS_W-1:0] TCP_SYN_BITS     = 8'h02;

	typedef enum logic {
		OP_PACKET = 1'b0,
		OP_TICK   = 1'b1
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		EV_BAN     = 2'd0,
		EV_EXPIRED = 2'd1,
		EV_FULL    = 2'd2
	} event_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RULE_PROTOCOL   = 3'd0,
		CFG_RULE_SYN_ONLY   = 3'd1,
		CFG_RULE_PPS_ABOVE  = 3'd2,
		CFG_RULE_MBPS_ABOVE = 3'd3,
		CFG_RULE_MBPS_BELOW = 3'd4,
		CFG_RULE_MIN_FLOWS  = 3'd5,
		CFG_RULE_HOLD       = 3'd6,
		CFG_GLOBAL_HOLD     = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_WALK,
		BK_FLUSH
	} back_state_t;

	// Rule settings as the datapath uses them; mbps limits are kept as bit-rate bounds
	typedef struct packed {
		logic [PROTO_W-1:0] protocol;
		logic               syn_only;
		logic [RATE_W-1:0]  pps_above;
		logic               mbps_above_on;
		logic [THR_W-1:0]   mbps_above_lo;  // mbps_above * 1e6
		logic [THR_W-1:0]   mbps_above_hi;  // (mbps_above + 1) * 1e6
		logic               mbps_below_on;
		logic [THR_W-1:0]   mbps_below_hi;  // (mbps_below + 1) * 1e6
		logic [FLOWS_W-1:0] min_flows;
		logic [HOLD_W-1:0]  rule_hold;
		logic [HOLD_W-1:0]  global_hold;
	} rules_t;

	// Work handed from the front to the back
	typedef struct packed {
		op_t                op;
		logic [TIME_W-1:0]  now;
		logic [ADDR_W-1:0]  addr;
		logic [PROTO_W-1:0] proto;
	} job_t;

endpackage

>>> design/rtbt_front.sv
// Front end: input register, rule evaluation and queue push.
module rtbt_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// now_seconds, src_addr, packet_protocol, packet_rate, bit_rate,
	// flow_count, tcp_flag_bits, exempt, zero fill
	input  logic [rtbt_pkg::S_TDATA_W-1:0]  s_tdata,
	// operation
	input  logic [0:0]                      s_tuser,
	input  rtbt_pkg::rules_t                rules,
	input  logic                            q_full,
	output logic                            push,
	output rtbt_pkg::job_t                  push_job
);

	logic                              valid_s1;
	rtbt_pkg::op_t                     op_s1;
	logic [rtbt_pkg::TIME_W-1:0]       now_s1;
	logic [rtbt_pkg::ADDR_W-1:0]       addr_s1;
	logic [rtbt_pkg::PROTO_W-1:0]      proto_s1;
	logic [rtbt_pkg::RATE_W-1:0]       pps_s1;
	logic [rtbt_pkg::BITS_W-1:0]       bits_s1;
	logic [rtbt_pkg::FLOWS_W-1:0]      flows_s1;
	logic [rtbt_pkg::FLAGS_W-1:0]      flags_s1;
	logic                              exempt_s1;

	logic                              fire;
	logic                              wanted;
	logic                              drain;
	logic [rtbt_pkg::THR_W-1:0]        bits_x;

	// Rule evaluation in the listed order; later tests override earlier ones
	always_comb begin
		bits_x = {1'b0, bits_s1};
		fire   = 1'b0;
		if (rules.pps_above != '0 && pps_s1 > rules.pps_above) fire = 1'b1;
		if (rules.mbps_above_on && bits_x >= rules.mbps_above_hi) fire = 1'b1;
		if (rules.mbps_above_on && bits_x < rules.mbps_above_lo) fire = 1'b0;
		if (rules.mbps_below_on && bits_x >= rules.mbps_below_hi) fire = 1'b0;
		if (rules.syn_only && flags_s1 != rtbt_pkg::TCP_SYN_BITS) fire = 1'b0;
		if (rules.min_flows != '0 && flows_s1 < rules.min_flows) fire = 1'b0;
		if (exempt_s1) fire = 1'b0;
	end

	// Ticks always go on; packets only when the protocol matches and the rule fires
	assign wanted = (op_s1 == rtbt_pkg::OP_TICK) || (proto_s1 == rules.protocol && fire);
	assign push   = valid_s1 && wanted && !q_full;
	assign drain  = valid_s1 && (!wanted || !q_full);
	assign s_tready = !valid_s1 || drain;

	assign push_job.op    = op_s1;
	assign push_job.now   = now_s1;
	assign push_job.addr  = addr_s1;
	assign push_job.proto = proto_s1;

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1     <= rtbt_pkg::op_t'(s_tuser[0]);
			now_s1    <= s_tdata[rtbt_pkg::OFF_NOW +: rtbt_pkg::TIME_W];
			addr_s1   <= s_tdata[rtbt_pkg::OFF_ADDR +: rtbt_pkg::ADDR_W];
			proto_s1  <= s_tdata[rtbt_pkg::OFF_PROTO +: rtbt_pkg::PROTO_W];
			pps_s1    <= s_tdata[rtbt_pkg::OFF_PPS +: rtbt_pkg::RATE_W];
			bits_s1   <= s_tdata[rtbt_pkg::OFF_BITS +: rtbt_pkg::BITS_W];
			flows_s1  <= s_tdata[rtbt_pkg::OFF_FLOWS +: rtbt_pkg::FLOWS_W];
			flags_s1  <= s_tdata[rtbt_pkg::OFF_FLAGS +: rtbt_pkg::FLAGS_W];
			exempt_s1 <= s_tdata[rtbt_pkg::OFF_EXEMPT];
		end
	end

endmodule

>>> design/rtbt_queue.sv
// Short job queue between the front and the back.
module rtbt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rtbt_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output rtbt_pkg::job_t pop_job,
	output logic           empty
);

	rtbt_pkg::job_t                  entry_q [rtbt_pkg::QUEUE_DEPTH];
	logic [rtbt_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [rtbt_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [rtbt_pkg::QCNT_W-1:0]     count_q;

	localparam logic [rtbt_pkg::QPTR_W-1:0] PTR_LAST = rtbt_pkg::QPTR_W'(rtbt_pkg::QUEUE_DEPTH - 1);
	localparam logic [rtbt_pkg::QCNT_W-1:0] CNT_FULL = rtbt_pkg::QCNT_W'(rtbt_pkg::QUEUE_DEPTH);

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign pop_job = entry_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_job;
	end

endmodule

>>> design/rtbt_back.sv
// Back end: ban slot table, packet bans, tick walk and output register.
`include "rate_threshold_ban_table_top_macros.svh"

module rtbt_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rtbt_pkg::rules_t                rules,
	input  logic                            q_empty,
	input  rtbt_pkg::job_t                  q_job,
	output logic                            pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// event_addr, event_protocol
	output logic [rtbt_pkg::M_TDATA_W-1:0]  m_tdata,
	// event_kind
	output logic [rtbt_pkg::KIND_W-1:0]     m_tuser,
	output logic                            m_tlast
);

	localparam logic [rtbt_pkg::SLOT_W-1:0] SLOT_LAST = rtbt_pkg::SLOT_W'(rtbt_pkg::BAN_SLOTS - 1);
	localparam logic [rtbt_pkg::EVT_CNT_W-1:0] EVT_MAX = rtbt_pkg::EVT_CNT_W'(rtbt_pkg::MAX_EVENTS);

	rtbt_pkg::back_state_t state_q, state_d;

	// Slot table
	logic [rtbt_pkg::BAN_SLOTS-1:0]   slot_valid_q;
	logic [rtbt_pkg::ADDR_W-1:0]      slot_addr_q  [rtbt_pkg::BAN_SLOTS];
	logic [rtbt_pkg::TIME_W-1:0]      slot_time_q  [rtbt_pkg::BAN_SLOTS];
	logic [rtbt_pkg::PROTO_W-1:0]     slot_proto_q [rtbt_pkg::BAN_SLOTS];

	// Tick walk
	logic [rtbt_pkg::SLOT_W-1:0]      idx_q;
	logic [rtbt_pkg::TIME_W-1:0]      now_q;
	logic [rtbt_pkg::EVT_CNT_W-1:0]   evt_cnt_q;
	logic                             pend_valid_q;
	logic [rtbt_pkg::ADDR_W-1:0]      pend_addr_q;
	logic [rtbt_pkg::PROTO_W-1:0]     pend_proto_q;

	// Output register
	logic                             out_valid_q;
	rtbt_pkg::event_kind_t            out_kind_q;
	logic [rtbt_pkg::ADDR_W-1:0]      out_addr_q;
	logic [rtbt_pkg::PROTO_W-1:0]     out_proto_q;
	logic                             out_last_q;
	logic                             out_free;

	// Lookup results
	logic                             hit;
	logic                             any_free;
	logic [rtbt_pkg::SLOT_W-1:0]      free_idx;
	logic [rtbt_pkg::TIME_W-1:0]      age;
	logic                             expired;
	logic                             take;

	// Control from the state machine
	logic                             emit;
	rtbt_pkg::event_kind_t            emit_kind;
	logic [rtbt_pkg::ADDR_W-1:0]      emit_addr;
	logic [rtbt_pkg::PROTO_W-1:0]     emit_proto;
	logic                             emit_last;
	logic                             slot_set;
	logic                             slot_clr;
	logic                             walk_start;
	logic                             walk_step;
	logic                             pend_load;
	logic                             pend_drop;

	assign out_free = !out_valid_q || m_tready;

	// Address match over all valid slots, lowest free slot
	always_comb begin
		hit      = 1'b0;
		free_idx = '0;
		for (int i = 0; i < rtbt_pkg::BAN_SLOTS; i++) begin
			if (slot_valid_q[i] && slot_addr_q[i] == q_job.addr) hit = 1'b1;
		end
		for (int i = rtbt_pkg::BAN_SLOTS - 1; i >= 0; i--) begin
			if (!slot_valid_q[i]) free_idx = rtbt_pkg::SLOT_W'(i);
		end
	end
	assign any_free = !(&slot_valid_q);

	// Expiry test on the slot under the walk
	assign age     = now_q - slot_time_q[idx_q];
	assign expired = slot_valid_q[idx_q]
		&& age >= {{(rtbt_pkg::TIME_W - rtbt_pkg::HOLD_W){1'b0}}, rules.global_hold}
		&& (rules.rule_hold == '0
			|| age >= {{(rtbt_pkg::TIME_W - rtbt_pkg::HOLD_W){1'b0}}, rules.rule_hold});
	assign take = expired && (evt_cnt_q < EVT_MAX);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtbt_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control
	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		emit       = 1'b0;
		emit_kind  = rtbt_pkg::EV_BAN;
		emit_addr  = q_job.addr;
		emit_proto = q_job.proto;
		emit_last  = 1'b1;
		slot_set   = 1'b0;
		slot_clr   = 1'b0;
		walk_start = 1'b0;
		walk_step  = 1'b0;
		pend_load  = 1'b0;
		pend_drop  = 1'b0;
		unique case (state_q)
			rtbt_pkg::BK_IDLE: begin
				if (!q_empty && out_free) begin
					pop = 1'b1;
					if (q_job.op == rtbt_pkg::OP_TICK) begin
						walk_start = 1'b1;
						state_d    = rtbt_pkg::BK_WALK;
					end else if (!hit) begin
						emit      = 1'b1;
						emit_kind = any_free ? rtbt_pkg::EV_BAN : rtbt_pkg::EV_FULL;
						slot_set  = any_free;
					end
				end
			end
			rtbt_pkg::BK_WALK: begin
				if (!pend_valid_q || out_free) begin
					walk_step = 1'b1;
					if (take) begin
						slot_clr   = 1'b1;
						pend_load  = 1'b1;
						emit       = pend_valid_q;
						emit_kind  = rtbt_pkg::EV_EXPIRED;
						emit_addr  = pend_addr_q;
						emit_proto = pend_proto_q;
						emit_last  = 1'b0;
					end
					if (idx_q == SLOT_LAST) state_d = rtbt_pkg::BK_FLUSH;
				end
			end
			rtbt_pkg::BK_FLUSH: begin
				if (!pend_valid_q) begin
					state_d = rtbt_pkg::BK_IDLE;
				end else if (out_free) begin
					emit       = 1'b1;
					emit_kind  = rtbt_pkg::EV_EXPIRED;
					emit_addr  = pend_addr_q;
					emit_proto = pend_proto_q;
					emit_last  = 1'b1;
					pend_drop  = 1'b1;
					state_d    = rtbt_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = rtbt_pkg::BK_IDLE;
			end
		endcase
	end

	// Control registers: valid bits, walk counters, pending and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			idx_q        <= '0;
			evt_cnt_q    <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (slot_set) slot_valid_q[free_idx] <= 1'b1;
			if (slot_clr) slot_valid_q[idx_q] <= 1'b0;
			if (walk_start) begin
				idx_q        <= '0;
				evt_cnt_q    <= '0;
				pend_valid_q <= 1'b0;
			end else begin
				if (walk_step && idx_q != SLOT_LAST) idx_q <= idx_q + 1'b1;
				if (pend_load) begin
					evt_cnt_q    <= evt_cnt_q + 1'b1;
					pend_valid_q <= 1'b1;
				end else if (pend_drop) begin
					pend_valid_q <= 1'b0;
				end
			end
			if (emit) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (slot_set) begin
			slot_addr_q[free_idx]  <= q_job.addr;
			slot_time_q[free_idx]  <= q_job.now;
			slot_proto_q[free_idx] <= q_job.proto;
		end
		if (walk_start) now_q <= q_job.now;
		if (pend_load) begin
			pend_addr_q  <= slot_addr_q[idx_q];
			pend_proto_q <= slot_proto_q[idx_q];
		end
		if (emit) begin
			out_kind_q  <= emit_kind;
			out_addr_q  <= emit_addr;
			out_proto_q <= emit_proto;
			out_last_q  <= emit_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = rtbt_pkg::M_TDATA_W'({out_proto_q, out_addr_q});
	assign m_tlast  = out_last_q;

	// Jobs leave the queue only while no walk is running
	`RTBT_ASSERT_IMP(a_pop_idle, pop, state_q == rtbt_pkg::BK_IDLE && !q_empty)
	// A new ban fills exactly one slot
	`RTBT_ASSERT_NEXT(a_ban_fills_one, slot_set,
		$countones(slot_valid_q) == $countones($past(slot_valid_q)) + 1)
	// A walk never frees more than the event limit
	`RTBT_ASSERT_IMP(a_evt_limit, state_q != rtbt_pkg::BK_IDLE, evt_cnt_q <= EVT_MAX)
	// The held expiry at the end of a walk goes out as the last event
	`RTBT_ASSERT_NEXT(a_flush_last,
		state_q == rtbt_pkg::BK_FLUSH && pend_valid_q && out_free,
		m_tvalid && m_tlast && m_tuser == rtbt_pkg::EV_EXPIRED)

endmodule

>>> design/rate_threshold_ban_table_top.sv
// Top level: rule registers, front end, job queue and ban table back end.
// A ban or table-full event passes the input register, the job queue and the output register.
// Packet checks sustain one per cycle unless the queue is full; a tick holds the back end for
// the pop, the walk (one slot per cycle, single age subtractor), the flush and output stalls.
// Reset (arst_n low, asynchronous) clears the rule registers, slot valid bits, queue and
// handshake state; slot contents need no clearing, so the block is ready right after reset.
module rate_threshold_ban_table_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// now_seconds, src_addr, packet_protocol, packet_rate, bit_rate,
	// flow_count, tcp_flag_bits, exempt, zero fill
	input  logic [rtbt_pkg::S_TDATA_W-1:0]  s_tdata,
	// operation
	input  logic [0:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// event_addr, event_protocol
	output logic [rtbt_pkg::M_TDATA_W-1:0]  m_tdata,
	// event_kind
	output logic [rtbt_pkg::KIND_W-1:0]     m_tuser,
	output logic                            m_tlast,
	input  logic                            cfg_we,
	input  logic [rtbt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rtbt_pkg::CFG_W-1:0]      cfg_data
);

	logic [rtbt_pkg::PROTO_W-1:0]  protocol_q;
	logic                          syn_only_q;
	logic [rtbt_pkg::RATE_W-1:0]   pps_above_q;
	logic                          mbps_above_on_q;
	logic [rtbt_pkg::THR_W-1:0]    mbps_above_lo_q;
	logic [rtbt_pkg::THR_W-1:0]    mbps_above_hi_q;
	logic                          mbps_below_on_q;
	logic [rtbt_pkg::THR_W-1:0]    mbps_below_hi_q;
	logic [rtbt_pkg::FLOWS_W-1:0]  min_flows_q;
	logic [rtbt_pkg::HOLD_W-1:0]   rule_hold_q;
	logic [rtbt_pkg::HOLD_W-1:0]   global_hold_q;

	logic [rtbt_pkg::MBPS_W-1:0]   cfg_mbps;
	logic [rtbt_pkg::THR_W-1:0]    mbps_lo;
	logic [rtbt_pkg::THR_W-1:0]    mbps_hi;

	rtbt_pkg::rules_t              rules;
	logic                          push;
	rtbt_pkg::job_t                push_job;
	logic                          q_full;
	logic                          q_empty;
	logic                          pop;
	rtbt_pkg::job_t                q_job;

	// Megabit limits turned into bit-rate bounds at write time
	assign cfg_mbps = cfg_data[rtbt_pkg::MBPS_W-1:0];
	assign mbps_lo  = rtbt_pkg::THR_W'(cfg_mbps) * rtbt_pkg::BITS_PER_MEGABIT;
	assign mbps_hi  = (rtbt_pkg::THR_W'(cfg_mbps) + 1'b1) * rtbt_pkg::BITS_PER_MEGABIT;

	// Rule register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			protocol_q      <= '0;
			syn_only_q      <= 1'b0;
			pps_above_q     <= '0;
			mbps_above_on_q <= 1'b0;
			mbps_above_lo_q <= '0;
			mbps_above_hi_q <= '0;
			mbps_below_on_q <= 1'b0;
			mbps_below_hi_q <= '0;
			min_flows_q     <= '0;
			rule_hold_q     <= '0;
			global_hold_q   <= '0;
		end else if (cfg_we) begin
			unique case (rtbt_pkg::cfg_idx_t'(cfg_index))
				rtbt_pkg::CFG_RULE_PROTOCOL: protocol_q <= cfg_data[rtbt_pkg::PROTO_W-1:0];
				rtbt_pkg::CFG_RULE_SYN_ONLY: syn_only_q <= cfg_data[0];
				rtbt_pkg::CFG_RULE_PPS_ABOVE: pps_above_q <= cfg_data[rtbt_pkg::RATE_W-1:0];
				rtbt_pkg::CFG_RULE_MBPS_ABOVE: begin
					mbps_above_on_q <= (cfg_mbps != '0);
					mbps_above_lo_q <= mbps_lo;
					mbps_above_hi_q <= mbps_hi;
				end
				rtbt_pkg::CFG_RULE_MBPS_BELOW: begin
					mbps_below_on_q <= (cfg_mbps != '0);
					mbps_below_hi_q <= mbps_hi;
				end
				rtbt_pkg::CFG_RULE_MIN_FLOWS: min_flows_q <= cfg_data[rtbt_pkg::FLOWS_W-1:0];
				rtbt_pkg::CFG_RULE_HOLD: rule_hold_q <= cfg_data[rtbt_pkg::HOLD_W-1:0];
				rtbt_pkg::CFG_GLOBAL_HOLD: global_hold_q <= cfg_data[rtbt_pkg::HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	assign rules.protocol      = protocol_q;
	assign rules.syn_only      = syn_only_q;
	assign rules.pps_above     = pps_above_q;
	assign rules.mbps_above_on = mbps_above_on_q;
	assign rules.mbps_above_lo = mbps_above_lo_q;
	assign rules.mbps_above_hi = mbps_above_hi_q;
	assign rules.mbps_below_on = mbps_below_on_q;
	assign rules.mbps_below_hi = mbps_below_hi_q;
	assign rules.min_flows     = min_flows_q;
	assign rules.rule_hold     = rule_hold_q;
	assign rules.global_hold   = global_hold_q;

	rtbt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.rules    (rules),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	rtbt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.pop_job  (q_job),
		.empty    (q_empty)
	);

	rtbt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rules    (rules),
		.q_empty  (q_empty),
		.q_job    (q_job),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
